// File: rtl/core/smcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcs_pkg
// Shared sizes, codes and control types of the sparse matrix coordinate store.
// ----------------------------------------------------------------------------
package smcs_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int MAX_DIM     = 64;
  localparam int SYM_W       = 8;
  localparam int DIM_W       = 7;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int STATUS_W    = 2;

  // operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic [SYM_W-1:0] sym;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  typedef enum logic [2:0] {
    FIN_OK,
    FIN_RANGE,
    FIN_FULL,
    FIN_HIT_READ,
    FIN_MISS_READ
  } fin_t;

  typedef struct packed {
    logic load;
    logic clr_idx;
    logic inc_idx;
    logic rd_en;
    logic rd_next;
    logic wr_en;
    logic wr_copy;
    logic cnt_inc;
    logic cnt_dec;
    logic finish;
    fin_t fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_of_range;
    logic at_end;
    logic match;
    logic op_write;
    logic sym_default;
    logic full;
    logic shift_last;
  } dp_status_t;

endpackage

// File: rtl/core/smcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcs_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module smcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/smcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcs_ctrl
// Sequencer for range check, linear entry scan, update, append and compaction.
// ----------------------------------------------------------------------------
module smcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  smcs_pkg::dp_status_t st,
  output smcs_pkg::ctl_cmd_t   cmd
);

  import smcs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = st.out_of_range ? S_IDLE : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_next = st.at_end ? S_IDLE : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (!st.match) begin
          state_next = S_SCAN_RD;
        end else if (st.op_write && st.sym_default) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT_RD: begin
        state_next = st.shift_last ? S_IDLE : S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_next = S_SHIFT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    cmd.fin = FIN_OK;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_CHECK: begin
        if (st.out_of_range) begin
          cmd.finish = 1'b1;
          cmd.fin    = FIN_RANGE;
        end else begin
          cmd.clr_idx = 1'b1;
        end
      end
      S_SCAN_RD: begin
        if (!st.at_end) begin
          cmd.rd_en = 1'b1;
        end else begin
          // no entry for this cell
          cmd.finish = 1'b1;
          if (!st.op_write) begin
            cmd.fin = FIN_MISS_READ;
          end else if (st.sym_default) begin
            cmd.fin = FIN_OK;
          end else if (st.full) begin
            cmd.fin = FIN_FULL;
          end else begin
            // append at idx, which equals the count here
            cmd.wr_en   = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.fin     = FIN_OK;
          end
        end
      end
      S_SCAN_CMP: begin
        if (!st.match) begin
          cmd.inc_idx = 1'b1;
        end else if (!st.op_write) begin
          cmd.finish = 1'b1;
          cmd.fin    = FIN_HIT_READ;
        end else if (!st.sym_default) begin
          cmd.wr_en  = 1'b1;
          cmd.finish = 1'b1;
          cmd.fin    = FIN_OK;
        end
      end
      S_SHIFT_RD: begin
        if (st.shift_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.finish  = 1'b1;
          cmd.fin     = FIN_OK;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_copy = 1'b1;
        cmd.inc_idx = 1'b1;
      end
      default: begin
        cmd.fin = FIN_OK;
      end
    endcase
  end

endmodule

// File: rtl/core/smcs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcs_datapath
// Item and configuration registers, scan index, entry count, entry RAM and
// result registers.
// ----------------------------------------------------------------------------
module smcs_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  smcs_pkg::ctl_cmd_t              cmd,
  output smcs_pkg::dp_status_t            st,
  input  logic                            operation,
  input  logic [smcs_pkg::DIM_W-1:0]      row,
  input  logic [smcs_pkg::DIM_W-1:0]      column,
  input  logic [smcs_pkg::SYM_W-1:0]      write_symbol,
  input  logic                            cfg_we,
  input  logic [smcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smcs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            done,
  output logic [smcs_pkg::SYM_W-1:0]      read_symbol,
  output logic [smcs_pkg::STATUS_W-1:0]   status,
  output logic [smcs_pkg::CNT_W-1:0]      entries_used
);

  import smcs_pkg::*;

  logic [DIM_W-1:0] rows_in_use;
  logic [DIM_W-1:0] cols_in_use;
  logic [SYM_W-1:0] default_symbol;

  logic             op_q;
  logic [DIM_W-1:0] row_q;
  logic [DIM_W-1:0] col_q;
  logic [SYM_W-1:0] sym_q;

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_plus;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  entry_t           rdata;
  entry_t           wdata;
  logic [ADDR_W-1:0] raddr;

  logic [SYM_W-1:0]    rd_val;
  logic [STATUS_W-1:0] st_val;
  logic                row_ok;
  logic                col_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use    <= DIM_W'(16);
      cols_in_use    <= DIM_W'(16);
      default_symbol <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS:    rows_in_use    <= cfg_data[DIM_W-1:0];
        REG_COLS:    cols_in_use    <= cfg_data[DIM_W-1:0];
        REG_DEFAULT: default_symbol <= cfg_data[SYM_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      row_q <= row;
      col_q <= column;
      sym_q <= write_symbol;
    end
  end

  // bound is the smaller of the size register and the largest dimension
  assign row_ok = (row_q != '0) && (32'(row_q) <= 32'(rows_in_use))
                  && (32'(row_q) <= MAX_DIM);
  assign col_ok = (col_q != '0) && (32'(col_q) <= 32'(cols_in_use))
                  && (32'(col_q) <= MAX_DIM);

  assign idx_plus = idx + CNT_W'(1);

  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx_plus;
      end
    end
  end

  assign st.out_of_range = !(row_ok && col_ok);
  assign st.at_end       = (idx == count);
  assign st.match        = (rdata.row == row_q) && (rdata.col == col_q);
  assign st.op_write     = (op_q == OP_WRITE);
  assign st.sym_default  = (sym_q == default_symbol);
  assign st.full         = (count == CNT_W'(MAX_ENTRIES));
  assign st.shift_last   = (idx_plus == count);

  // compaction copies the next entry down onto the current slot
  assign raddr = cmd.rd_next ? idx_plus[ADDR_W-1:0] : idx[ADDR_W-1:0];

  always_comb begin
    if (cmd.wr_copy) begin
      wdata = rdata;
    end else begin
      wdata.row = row_q;
      wdata.col = col_q;
      wdata.sym = sym_q;
    end
  end

  smcs_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (idx[ADDR_W-1:0]),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    rd_val = '0;
    st_val = ST_OK;
    unique case (cmd.fin)
      FIN_OK:        ;
      FIN_RANGE:     st_val = ST_RANGE;
      FIN_FULL:      st_val = ST_FULL;
      FIN_HIT_READ:  rd_val = rdata.sym;
      FIN_MISS_READ: rd_val = default_symbol;
      default:       ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_symbol  <= rd_val;
      status       <= st_val;
      entries_used <= count_next;
    end
  end

endmodule

// File: rtl/core/sparse_matrix_coordinate_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_matrix_coordinate_store_core
// Sparse matrix kept as a compacted list of (row, column, symbol) entries.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result word
// appears on read_symbol, status and entries_used for exactly one cycle with
// done high, and must be captured then since the receiver cannot hold it off.
// Each command checks the range, then scans the entry RAM one entry at a time,
// reading each entry and then comparing it. A removal then compacts the list
// through the single RAM port pair, reading each later entry and writing it
// one slot down. The entry RAM needs no clearing after reset; configuration
// writes must be made only while the block is idle, which the block itself
// does not enforce.
module sparse_matrix_coordinate_store_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation,
  input  logic [smcs_pkg::DIM_W-1:0]      row,
  input  logic [smcs_pkg::DIM_W-1:0]      column,
  input  logic [smcs_pkg::SYM_W-1:0]      write_symbol,
  output logic                            done,
  output logic [smcs_pkg::SYM_W-1:0]      read_symbol,
  output logic [smcs_pkg::STATUS_W-1:0]   status,
  output logic [smcs_pkg::CNT_W-1:0]      entries_used,
  input  logic                            cfg_we,
  input  logic [smcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smcs_pkg::CFG_DATA_W-1:0] cfg_data
);

  import smcs_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;

  smcs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  smcs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .operation    (operation),
    .row          (row),
    .column       (column),
    .write_symbol (write_symbol),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .read_symbol  (read_symbol),
    .status       (status),
    .entries_used (entries_used)
  );

endmodule
